@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Flag a condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ hdl/irc_lbc_pkg.sv @@
// Shared types and constants of the IRC line byte classifier.
`default_nettype none

package irc_lbc_pkg;

   // Byte class codes
   localparam logic [3:0] CL_TAGMARK    = 4'd0;
   localparam logic [3:0] CL_KEY        = 4'd1;
   localparam logic [3:0] CL_EQUALS     = 4'd2;
   localparam logic [3:0] CL_VALUE      = 4'd3;
   localparam logic [3:0] CL_SEMI       = 4'd4;
   localparam logic [3:0] CL_PREFIXMARK = 4'd5;
   localparam logic [3:0] CL_NICK       = 4'd6;
   localparam logic [3:0] CL_PREFIXREST = 4'd7;
   localparam logic [3:0] CL_SPACE      = 4'd8;
   localparam logic [3:0] CL_COMMAND    = 4'd9;
   localparam logic [3:0] CL_PARAM      = 4'd10;
   localparam logic [3:0] CL_TRAILMARK  = 4'd11;
   localparam logic [3:0] CL_TRAILING   = 4'd12;

   // Delimiter characters
   localparam logic [7:0] CHAR_AT    = 8'h40;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_EQ    = 8'h3D;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_BANG  = 8'h21;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef struct packed {
      logic [7:0] byte_out;
      logic [3:0] byte_class;
      logic [5:0] item_index;
      logic       line_end;
      logic       line_ok;
   } rsp_type;

endpackage

`default_nettype wire

@@ hdl/irc_lbc_front.sv @@
// Front end: per-byte parse state machine that labels each accepted item.
`default_nettype none

module irc_lbc_front
   import irc_lbc_pkg::*;
#(
   parameter int TAG_INDEX_LIMIT   = 63,
   parameter int PARAM_INDEX_LIMIT = 15
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] data_byte,
   input  wire logic       last_byte,
   output rsp_type         result
);

   localparam logic [5:0] TagCap   = (TAG_INDEX_LIMIT > 63) ? 6'd63 : 6'(TAG_INDEX_LIMIT);
   localparam logic [3:0] ParamCap = (PARAM_INDEX_LIMIT > 15) ? 4'd15 : 4'(PARAM_INDEX_LIMIT);

   typedef enum logic [3:0] {
      PH_START      = 4'd0,
      PH_TAGS       = 4'd1,
      PH_TAG_GAP    = 4'd2,
      PH_PREFIX     = 4'd3,
      PH_PREFIX_GAP = 4'd4,
      PH_COMMAND    = 4'd5,
      PH_PARAM_GAP  = 4'd6,
      PH_PARAM      = 4'd7,
      PH_TRAILING   = 4'd8
   } phase_type;

   phase_type  phase_ff, phase_in, phase_step;
   logic       equals_ff, equals_in, equals_step;
   logic       bang_ff, bang_in, bang_step;
   logic [5:0] tag_ff, tag_in, tag_step;
   logic [3:0] param_ff, param_in, param_step;
   logic [3:0] cls;
   logic [5:0] idx;
   logic       ok;

   always_comb begin
      phase_step  = phase_ff;
      equals_step = equals_ff;
      bang_step   = bang_ff;
      tag_step    = tag_ff;
      param_step  = param_ff;
      idx         = 6'd0;
      case (phase_ff)
         PH_TAGS: begin
            idx = tag_ff;
            if (data_byte == CHAR_SPACE) begin
               cls        = CL_SPACE;
               idx        = 6'd0;
               phase_step = PH_TAG_GAP;
            end else if (data_byte == CHAR_SEMI) begin
               cls = CL_SEMI;
               if (tag_ff < TagCap) tag_step = tag_ff + 6'd1;
               equals_step = 1'b0;
            end else if (data_byte == CHAR_EQ && !equals_ff) begin
               cls         = CL_EQUALS;
               equals_step = 1'b1;
            end else begin
               cls = equals_ff ? CL_VALUE : CL_KEY;
            end
         end
         PH_TAG_GAP: begin
            if (data_byte == CHAR_SPACE) begin
               cls = CL_SPACE;
            end else if (data_byte == CHAR_COLON) begin
               cls        = CL_PREFIXMARK;
               phase_step = PH_PREFIX;
            end else begin
               cls        = CL_COMMAND;
               phase_step = PH_COMMAND;
            end
         end
         PH_PREFIX: begin
            if (data_byte == CHAR_SPACE) begin
               cls        = CL_SPACE;
               phase_step = PH_PREFIX_GAP;
            end else if (bang_ff) begin
               cls = CL_PREFIXREST;
            end else if (data_byte == CHAR_BANG) begin
               cls       = CL_PREFIXREST;
               bang_step = 1'b1;
            end else begin
               cls = CL_NICK;
            end
         end
         PH_PREFIX_GAP: begin
            if (data_byte == CHAR_SPACE) begin
               cls = CL_SPACE;
            end else begin
               cls        = CL_COMMAND;
               phase_step = PH_COMMAND;
            end
         end
         PH_COMMAND: begin
            if (data_byte == CHAR_SPACE) begin
               cls        = CL_SPACE;
               phase_step = PH_PARAM_GAP;
            end else begin
               cls = CL_COMMAND;
            end
         end
         PH_PARAM_GAP: begin
            if (data_byte == CHAR_SPACE) begin
               cls = CL_SPACE;
            end else if (data_byte == CHAR_COLON) begin
               cls        = CL_TRAILMARK;
               idx        = {2'b00, param_ff};
               phase_step = PH_TRAILING;
            end else begin
               cls        = CL_PARAM;
               idx        = {2'b00, param_ff};
               phase_step = PH_PARAM;
            end
         end
         PH_PARAM: begin
            if (data_byte == CHAR_SPACE) begin
               cls = CL_SPACE;
               if (param_ff < ParamCap) param_step = param_ff + 4'd1;
               phase_step = PH_PARAM_GAP;
            end else begin
               cls = CL_PARAM;
               idx = {2'b00, param_ff};
            end
         end
         PH_TRAILING: begin
            cls = CL_TRAILING;
            idx = {2'b00, param_ff};
         end
         default: begin
            // Line start; unused codes act the same
            if (data_byte == CHAR_AT) begin
               cls        = CL_TAGMARK;
               phase_step = PH_TAGS;
            end else if (data_byte == CHAR_COLON) begin
               cls        = CL_PREFIXMARK;
               phase_step = PH_PREFIX;
            end else if (data_byte == CHAR_SPACE) begin
               cls        = CL_SPACE;
               phase_step = PH_PARAM_GAP;
            end else begin
               cls        = CL_COMMAND;
               phase_step = PH_COMMAND;
            end
         end
      endcase

      ok = last_byte && (phase_step inside {PH_COMMAND, PH_PARAM_GAP, PH_PARAM, PH_TRAILING});

      // Hold when idle; clear for the next line after the last item
      if (!accept) begin
         phase_in  = phase_ff;
         equals_in = equals_ff;
         bang_in   = bang_ff;
         tag_in    = tag_ff;
         param_in  = param_ff;
      end else if (last_byte) begin
         phase_in  = PH_START;
         equals_in = 1'b0;
         bang_in   = 1'b0;
         tag_in    = 6'd0;
         param_in  = 4'd0;
      end else begin
         phase_in  = phase_step;
         equals_in = equals_step;
         bang_in   = bang_step;
         tag_in    = tag_step;
         param_in  = param_step;
      end

      result.byte_out   = data_byte;
      result.byte_class = cls;
      result.item_index = idx;
      result.line_end   = last_byte;
      result.line_ok    = ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         equals_ff <= 1'b0;
         bang_ff   <= 1'b0;
         tag_ff    <= 6'd0;
         param_ff  <= 4'd0;
      end else begin
         phase_ff  <= phase_in;
         equals_ff <= equals_in;
         bang_ff   <= bang_in;
         tag_ff    <= tag_in;
         param_ff  <= param_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/irc_lbc_queue.sv @@
// Short FIFO of labeled items between the front and back ends.
`default_nettype none

module irc_lbc_queue
   import irc_lbc_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire rsp_type  push_data,
   input  wire logic     pop,
   output rsp_type       pop_data,
   output logic          full,
   output logic          empty
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

   rsp_type               slot_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign full     = (cnt_ff == FullCnt);
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == LastPtr) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == LastPtr) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop)      cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_data;
   end

endmodule

`default_nettype wire

@@ hdl/irc_lbc_back.sv @@
// Back end: output register that drains the queue toward the result ports.
`default_nettype none

module irc_lbc_back
   import irc_lbc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_empty,
   input  wire rsp_type  q_data,
   output logic          q_pop,
   input  wire logic     out_pop,
   output logic          out_empty,
   output rsp_type       out_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // Refill whenever the register is free or is taken this cycle
   assign q_pop     = !q_empty && (!valid_ff || out_pop);
   assign valid_in  = q_pop || (valid_ff && !out_pop);
   assign out_empty = !valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (q_pop) data_ff <= q_data;
   end

endmodule

`default_nettype wire

@@ hdl/irc_line_byte_classifier.sv @@
// Top level of the IRC line byte classifier.
//
//   channel   direction   handshake         payload
//   req       in          push / full       data_byte, last_byte
//   rsp       out         empty / pop       byte_out, byte_class, item_index,
//                                           line_end, line_ok
//
// One item is accepted per cycle while req_full is low; the per-byte parse
// step is a single state update in the front end, so a new byte may follow
// in every cycle. A result reaches the rsp ports through the queue and then
// the output register, loaded when that is free or being popped. If rsp
// stalls, the queue absorbs QUEUE_DEPTH items plus one in the output
// register before full rises.
// Synchronous reset returns the parser to line start and empties the queue.
`default_nettype none

module irc_line_byte_classifier
   import irc_lbc_pkg::*;
#(
   parameter int TAG_INDEX_LIMIT   = 63,
   parameter int PARAM_INDEX_LIMIT = 15,
   parameter int QUEUE_DEPTH       = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // Input channel
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   // Result channel
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_byte_out,
   output logic [3:0]      rsp_byte_class,
   output logic [5:0]      rsp_item_index,
   output logic            rsp_line_end,
   output logic            rsp_line_ok
);

   logic    accept;
   rsp_type front_result;
   rsp_type q_data;
   logic    q_empty, q_pop;
   rsp_type out_data;

   // Take an item only while the queue has room
   assign accept = req_push && !req_full;

   // Classify each accepted byte and advance the parse state
   irc_lbc_front #(
      .TAG_INDEX_LIMIT  (TAG_INDEX_LIMIT),
      .PARAM_INDEX_LIMIT(PARAM_INDEX_LIMIT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .data_byte(req_data_byte),
      .last_byte(req_last_byte),
      .result   (front_result)
   );

   // Hold labeled items so the front keeps going while rsp stalls
   irc_lbc_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_data(front_result),
      .pop      (q_pop),
      .pop_data (q_data),
      .full     (req_full),
      .empty    (q_empty)
   );

   // Present the oldest item on registered result ports
   irc_lbc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_data),
      .q_pop    (q_pop),
      .out_pop  (rsp_pop),
      .out_empty(rsp_empty),
      .out_data (out_data)
   );

   assign rsp_byte_out   = out_data.byte_out;
   assign rsp_byte_class = out_data.byte_class;
   assign rsp_item_index = out_data.item_index;
   assign rsp_line_end   = out_data.line_end;
   assign rsp_line_ok    = out_data.line_ok;

endmodule

`default_nettype wire

@@ hdl/irc_lbc_checker.sv @@
// Port-level checker for the IRC line byte classifier, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module irc_lbc_checker
   import irc_lbc_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_empty,
   input wire logic       rsp_pop,
   input wire logic [7:0] rsp_byte_out,
   input wire logic [3:0] rsp_byte_class,
   input wire logic [5:0] rsp_item_index,
   input wire logic       rsp_line_end,
   input wire logic       rsp_line_ok
);

   rsp_type rsp_fields;
   logic    rsp_stalled;
   logic    unindexed_class;

   assign rsp_fields  = {rsp_byte_out, rsp_byte_class, rsp_item_index, rsp_line_end,
                         rsp_line_ok};
   assign rsp_stalled = !rsp_empty && !rsp_pop;

   // Classes that never carry a tag or parameter number
   assign unindexed_class = (rsp_byte_class == CL_TAGMARK) ||
                            (rsp_byte_class == CL_PREFIXMARK) ||
                            (rsp_byte_class == CL_NICK) ||
                            (rsp_byte_class == CL_PREFIXREST) ||
                            (rsp_byte_class == CL_SPACE) ||
                            (rsp_byte_class == CL_COMMAND);

   `ASSERT_PROP(a_reset_empties, clock, 1'b0, reset |=> rsp_empty, "rsp not empty after reset")

   `ASSERT_PROP(a_stall_holds, clock, reset, rsp_stalled |=> (!rsp_empty && $stable(rsp_fields)), "stalled item changed")

   `ASSERT_NEVER(a_class_range, clock, reset, !rsp_empty && rsp_byte_class > CL_TRAILING, "byte class out of range")

   `ASSERT_NEVER(a_ok_only_at_end, clock, reset, !rsp_empty && rsp_line_ok && !rsp_line_end, "line_ok without line_end")

   `ASSERT_NEVER(a_index_zero, clock, reset, !rsp_empty && rsp_item_index != 6'd0 && unindexed_class, "index on unindexed class")

endmodule

bind irc_line_byte_classifier irc_lbc_checker u_checker (.*);

`default_nettype wire

@@ tb/sv/tb_irc_line_byte_classifier.sv @@
// Self-checking testbench for the IRC line byte classifier.
module tb_irc_line_byte_classifier;
   timeunit 1ns;
   timeprecision 1ps;

   import irc_lbc_pkg::*;

   // Index saturation points of the block at its default parameters
   localparam int unsigned TAG_CAP         = 63;
   localparam int unsigned PARAM_CAP       = 15;
   // Stimulus and run control
   localparam int unsigned RANDOM_BYTES    = 1750;
   localparam int unsigned HOLD_CYCLES     = 80;
   localparam int unsigned DRAIN_CYCLES    = 8;
   localparam int unsigned WATCHDOG_LIMIT  = 2000;
   localparam int unsigned MAX_REPORTS     = 10;

   // Parse position within the current line
   typedef enum logic [3:0] {
      PH_LINE_START, PH_TAGS, PH_TAG_GAP, PH_PREFIX, PH_PREFIX_GAP,
      PH_COMMAND, PH_PARAM_GAP, PH_PARAM, PH_TRAILING
   } parse_phase_e;

   // Tracks the parse of the byte stream and holds the labels still owed by the block.
   class line_label_checker;
      parse_phase_e phase;
      bit           eq_seen;
      bit           bang_seen;
      logic [5:0]   tag_num;
      logic [3:0]   param_num;
      rsp_type      labels_due[$];
      int unsigned  errors;
      int unsigned  checked;
      int unsigned  good_lines;
      int unsigned  bad_lines;
      int unsigned  top_tag;
      int unsigned  top_param;

      function new();
         clear_line();
         errors = 0;
         checked = 0;
         good_lines = 0;
         bad_lines = 0;
         top_tag = 0;
         top_param = 0;
      endfunction

      function void clear_line();
         phase = PH_LINE_START;
         eq_seen = 0;
         bang_seen = 0;
         tag_num = '0;
         param_num = '0;
      endfunction

      function int unsigned waiting();
         return labels_due.size();
      endfunction

      // Work out the label of one accepted byte and queue it.
      function void note_byte(logic [7:0] data, logic last);
         rsp_type lbl;
         lbl.byte_out = data;
         lbl.item_index = '0;
         lbl.line_end = last;
         lbl.line_ok = 1'b0;
         case (phase)
            PH_TAGS: begin
               lbl.item_index = tag_num;
               if (data == CHAR_SPACE) begin
                  lbl.byte_class = CL_SPACE;
                  lbl.item_index = '0;
                  phase = PH_TAG_GAP;
               end else if (data == CHAR_SEMI) begin
                  lbl.byte_class = CL_SEMI;
                  if (tag_num < TAG_CAP) tag_num++;
                  eq_seen = 0;
               end else if (data == CHAR_EQ && !eq_seen) begin
                  lbl.byte_class = CL_EQUALS;
                  eq_seen = 1;
               end else begin
                  lbl.byte_class = eq_seen ? CL_VALUE : CL_KEY;
               end
            end
            PH_TAG_GAP: begin
               if (data == CHAR_SPACE) begin
                  lbl.byte_class = CL_SPACE;
               end else if (data == CHAR_COLON) begin
                  lbl.byte_class = CL_PREFIXMARK;
                  phase = PH_PREFIX;
               end else begin
                  lbl.byte_class = CL_COMMAND;
                  phase = PH_COMMAND;
               end
            end
            PH_PREFIX: begin
               if (data == CHAR_SPACE) begin
                  lbl.byte_class = CL_SPACE;
                  phase = PH_PREFIX_GAP;
               end else if (bang_seen) begin
                  lbl.byte_class = CL_PREFIXREST;
               end else if (data == CHAR_BANG) begin
                  lbl.byte_class = CL_PREFIXREST;
                  bang_seen = 1;
               end else begin
                  lbl.byte_class = CL_NICK;
               end
            end
            PH_PREFIX_GAP: begin
               if (data == CHAR_SPACE) begin
                  lbl.byte_class = CL_SPACE;
               end else begin
                  lbl.byte_class = CL_COMMAND;
                  phase = PH_COMMAND;
               end
            end
            PH_COMMAND: begin
               if (data == CHAR_SPACE) begin
                  lbl.byte_class = CL_SPACE;
                  phase = PH_PARAM_GAP;
               end else begin
                  lbl.byte_class = CL_COMMAND;
               end
            end
            PH_PARAM_GAP: begin
               if (data == CHAR_SPACE) begin
                  lbl.byte_class = CL_SPACE;
               end else if (data == CHAR_COLON) begin
                  lbl.byte_class = CL_TRAILMARK;
                  lbl.item_index = 6'(param_num);
                  phase = PH_TRAILING;
               end else begin
                  lbl.byte_class = CL_PARAM;
                  lbl.item_index = 6'(param_num);
                  phase = PH_PARAM;
               end
            end
            PH_PARAM: begin
               if (data == CHAR_SPACE) begin
                  lbl.byte_class = CL_SPACE;
                  if (param_num < PARAM_CAP) param_num++;
                  phase = PH_PARAM_GAP;
               end else begin
                  lbl.byte_class = CL_PARAM;
                  lbl.item_index = 6'(param_num);
               end
            end
            PH_TRAILING: begin
               lbl.byte_class = CL_TRAILING;
               lbl.item_index = 6'(param_num);
            end
            default: begin
               if (data == CHAR_AT) begin
                  lbl.byte_class = CL_TAGMARK;
                  phase = PH_TAGS;
               end else if (data == CHAR_COLON) begin
                  lbl.byte_class = CL_PREFIXMARK;
                  phase = PH_PREFIX;
               end else if (data == CHAR_SPACE) begin
                  lbl.byte_class = CL_SPACE;
                  phase = PH_PARAM_GAP;
               end else begin
                  lbl.byte_class = CL_COMMAND;
                  phase = PH_COMMAND;
               end
            end
         endcase

         if (lbl.byte_class inside {CL_KEY, CL_EQUALS, CL_VALUE, CL_SEMI} &&
             lbl.item_index > top_tag)
            top_tag = lbl.item_index;
         if (lbl.byte_class inside {CL_PARAM, CL_TRAILMARK, CL_TRAILING} &&
             lbl.item_index > top_param)
            top_param = lbl.item_index;

         // A line parses once it has reached the command or anything after it
         if (last) begin
            lbl.line_ok = phase inside {PH_COMMAND, PH_PARAM_GAP, PH_PARAM, PH_TRAILING};
            if (lbl.line_ok) good_lines++;
            else bad_lines++;
            clear_line();
         end
         labels_due.push_back(lbl);
      endfunction

      // Compare one result from the block with the oldest label owed.
      function void check_label(rsp_type got);
         rsp_type want;
         if (labels_due.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%t: unexpected result byte=%h class=%0d index=%0d end=%b ok=%b",
                        $realtime, got.byte_out, got.byte_class, got.item_index,
                        got.line_end, got.line_ok);
            return;
         end
         want = labels_due.pop_front();
         checked++;
         if (got.byte_out !== want.byte_out || got.byte_class !== want.byte_class ||
             got.item_index !== want.item_index || got.line_end !== want.line_end ||
             got.line_ok !== want.line_ok) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%t: label mismatch, expected byte=%h class=%0d index=%0d end=%b ok=%b, got byte=%h class=%0d index=%0d end=%b ok=%b",
                        $realtime, want.byte_out, want.byte_class, want.item_index,
                        want.line_end, want.line_ok, got.byte_out, got.byte_class,
                        got.item_index, got.line_end, got.line_ok);
         end
      endfunction
   endclass

   // Clock, reset and block ports; every input starts at a known value
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_byte_out;
   logic [3:0] rsp_byte_class;
   logic [5:0] rsp_item_index;
   logic       rsp_line_end;
   logic       rsp_line_ok;
   rsp_type    rsp_seen;

   assign rsp_seen = {rsp_byte_out, rsp_byte_class, rsp_item_index, rsp_line_end, rsp_line_ok};

   irc_line_byte_classifier dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_byte_out   (rsp_byte_out),
      .rsp_byte_class (rsp_byte_class),
      .rsp_item_index (rsp_item_index),
      .rsp_line_end   (rsp_line_end),
      .rsp_line_ok    (rsp_line_ok)
   );

   line_label_checker board = new();

   logic [7:0]  line_bytes[$];     // bytes of the line being built
   int unsigned bytes_sent = 0;
   int unsigned stall_cycles = 0;
   int unsigned holds_done = 0;
   bit          calm = 0;          // set: neither side idles
   bit          hold_off_req = 0;  // set: receiver holds off for a long stretch

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: end the run when no item moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%t: watchdog expired, %0d labels still owed", $realtime, board.waiting());
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Result side: drop pop at random, hold off on request, check each item popped.
   always begin
      @(negedge clock);
      if (hold_off_req) begin
         hold_off_req = 0;
         rsp_pop <= 1'b0;
         // hold off long enough for the queue to fill and stall the sender
         repeat (HOLD_CYCLES) @(negedge clock);
      end
      rsp_pop <= calm || $urandom_range(0, 99) >= 30;
      @(posedge clock);
      if (!reset && rsp_pop && !rsp_empty) board.check_label(rsp_seen);
   end

   // Offer one byte, idling at random first; return at the falling edge after it is taken.
   task automatic send_byte(input logic [7:0] data, input logic last);
      bit taken;
      while (!calm && $urandom_range(0, 99) < 30) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      taken = 0;
      while (!taken) begin
         @(posedge clock);
         taken = !req_full;
         if (taken) begin
            board.note_byte(data, last);
            bytes_sent++;
         end
         @(negedge clock);
      end
   endtask

   // Send a text as one line, marking its final character as last.
   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_byte(text[i], i == text.len() - 1);
   endtask

   task automatic send_line();
      for (int i = 0; i < line_bytes.size(); i++)
         send_byte(line_bytes[i], i == line_bytes.size() - 1);
   endtask

   // Append random non-space bytes; inside tags keep ';' and '=' out.
   function automatic void add_word(int unsigned len, bit in_tag);
      logic [7:0] pick;
      repeat (len) begin
         do pick = 8'($urandom_range(0, 255));
         while (pick == CHAR_SPACE || (in_tag && (pick == CHAR_SEMI || pick == CHAR_EQ)));
         line_bytes.push_back(pick);
      end
   endfunction

   function automatic void add_spaces(int unsigned count);
      repeat (count) line_bytes.push_back(CHAR_SPACE);
   endfunction

   // Build one line: mostly well-formed with random content, some cut short,
   // some pure noise made of delimiters and random bytes.
   function automatic void build_line();
      int unsigned n_tags;
      int unsigned n_params;
      int unsigned keep;
      bit          with_tags;
      bit          with_prefix;
      line_bytes.delete();

      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 7))
               0: line_bytes.push_back(CHAR_AT);
               1: line_bytes.push_back(CHAR_COLON);
               2: line_bytes.push_back(CHAR_SPACE);
               3: line_bytes.push_back(CHAR_SEMI);
               4: line_bytes.push_back(CHAR_EQ);
               5: line_bytes.push_back(CHAR_BANG);
               default: line_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
         end
         return;
      end

      // Tag section; now and then long enough to saturate the tag index
      with_tags = $urandom_range(0, 2) == 0;
      if (with_tags) begin
         line_bytes.push_back(CHAR_AT);
         n_tags = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 4);
         for (int t = 0; t < n_tags; t++) begin
            if (t != 0) line_bytes.push_back(CHAR_SEMI);
            add_word($urandom_range(0, 4), 1);
            if ($urandom_range(0, 2) != 0) begin
               line_bytes.push_back(CHAR_EQ);
               add_word($urandom_range(0, 4), 1);
               // a second '=' belongs to the value
               if ($urandom_range(0, 4) == 0) begin
                  line_bytes.push_back(CHAR_EQ);
                  add_word(1, 1);
               end
            end
         end
         add_spaces($urandom_range(1, 3));
      end

      // Prefix: nick, then maybe '!' and the rest, with a later '!' at times
      with_prefix = $urandom_range(0, 2) == 0;
      if (with_prefix) begin
         line_bytes.push_back(CHAR_COLON);
         add_word($urandom_range(0, 6), 0);
         if ($urandom_range(0, 1) == 1) begin
            line_bytes.push_back(CHAR_BANG);
            add_word($urandom_range(0, 6), 0);
            if ($urandom_range(0, 3) == 0) begin
               line_bytes.push_back(CHAR_BANG);
               add_word(1, 0);
            end
         end
         add_spaces($urandom_range(1, 2));
      end

      // Command, or leading spaces for an empty one
      if (!with_tags && !with_prefix && $urandom_range(0, 7) == 0) begin
         add_spaces($urandom_range(1, 2));
      end else begin
         if (with_prefix && $urandom_range(0, 5) == 0) line_bytes.push_back(CHAR_COLON);
         add_word($urandom_range(1, 6), 0);
      end

      // Middle parameters; now and then enough to saturate the index
      n_params = ($urandom_range(0, 15) == 0) ? $urandom_range(16, 20) : $urandom_range(0, 3);
      repeat (n_params) begin
         add_spaces($urandom_range(1, 2));
         add_word($urandom_range(1, 5), 0);
         if ($urandom_range(0, 5) == 0) begin
            line_bytes.push_back(CHAR_COLON);
            add_word(1, 0);
         end
      end

      // Trailing parameter with any bytes, or trailing spaces
      case ($urandom_range(0, 3))
         0, 1: begin
            add_spaces($urandom_range(1, 2));
            line_bytes.push_back(CHAR_COLON);
            repeat ($urandom_range(0, 6)) line_bytes.push_back(8'($urandom_range(0, 255)));
         end
         2: add_spaces($urandom_range(1, 2));
         default: ;
      endcase

      // Cut some lines short so they end in tags, prefix or gaps
      if ($urandom_range(0, 5) == 0 && line_bytes.size() > 1) begin
         keep = $urandom_range(1, line_bytes.size() - 1);
         while (line_bytes.size() > keep) void'(line_bytes.pop_back());
      end
   endfunction

   initial begin
      // Hold reset from the start, release it at a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed lines: full line with tags, second '=', repeated '!', ':' as
      // command and inside a param, trailing text; leading space; ends in
      // prefix; ends in tags; byte value extremes as one-byte commands.
      send_text("@a=b=;c :n!! : p:q :t");
      send_text(" X");
      send_text(":n");
      send_text("@k");
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b1);

      // Random lines; quiet stretch in the middle, two long receiver hold-offs
      while (bytes_sent < RANDOM_BYTES) begin
         calm = bytes_sent >= 700 && bytes_sent < 1000;
         if ((holds_done == 0 && bytes_sent >= 300) || (holds_done == 1 && bytes_sent >= 1300)) begin
            hold_off_req = 1;
            holds_done++;
         end
         build_line();
         send_line();
      end
      calm = 0;
      req_push <= 1'b0;

      // Drain: wait for every owed label, then wait on for any stray results
      while (board.waiting() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d lines (%0d parsed, %0d rejected), %0d labels checked",
               bytes_sent, board.good_lines + board.bad_lines, board.good_lines,
               board.bad_lines, board.checked);
      $display("Highest tag index %0d, highest parameter index %0d, %0d mismatches",
               board.top_tag, board.top_param, board.errors);
      if (board.errors == 0 && board.waiting() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/irc_lbc_pkg.sv
hdl/irc_lbc_front.sv
hdl/irc_lbc_queue.sv
hdl/irc_lbc_back.sv
hdl/irc_line_byte_classifier.sv
hdl/irc_lbc_checker.sv
tb/sv/tb_irc_line_byte_classifier.sv
